// ===== rtl/core/aff2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine 2D transform composer package
// Widths, fixed-point constants, operation codes and the shared
// multiply-accumulate with truncation and saturation.
// ----------------------------------------------------------------------------
package aff2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 24;
    localparam int OPD_W     = VAL_W + 1;
    localparam int PROD_W    = OPD_W + VAL_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int N_ENTRIES = 6;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] ONE_VAL =
        (FRAC_BITS >= VAL_W - 1) ? VAL_MAX : VAL_W'(longint'(1) << FRAC_BITS);

    typedef enum logic [2:0] {
        OP_IDENTITY  = 3'd0,
        OP_TRANSLATE = 3'd1,
        OP_SCALE     = 3'd2,
        OP_ROTATE    = 3'd3,
        OP_SHEAR     = 3'd4,
        OP_POINT     = 3'd5
    } op_t;

    // Computes (p*u + q*v + r * 2^FRAC_BITS) >> FRAC_BITS, saturated to VAL_W bits.
    function automatic logic signed [VAL_W-1:0] mac3(
        input logic signed [OPD_W-1:0] p,
        input logic signed [VAL_W-1:0] u,
        input logic signed [OPD_W-1:0] q,
        input logic signed [VAL_W-1:0] v,
        input logic signed [OPD_W-1:0] r
    );
        logic signed [PROD_W-1:0] prod_pu;
        logic signed [PROD_W-1:0] prod_qv;
        logic signed [ACC_W-1:0]  sum;
        logic signed [ACC_W-1:0]  shifted;
        logic signed [VAL_W-1:0]  result;
        prod_pu = p * u;
        prod_qv = q * v;
        sum     = ACC_W'(prod_pu) + ACC_W'(prod_qv) + (ACC_W'(r) <<< FRAC_BITS);
        shifted = sum >>> FRAC_BITS;
        if (shifted > ACC_W'(VAL_MAX))
        begin
            result = VAL_MAX;
        end
        else if (shifted < ACC_W'(VAL_MIN))
        begin
            result = VAL_MIN;
        end
        else
        begin
            result = shifted[VAL_W-1:0];
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/affine_2d_transform_composer_core.sv =====
`timescale 1ns / 1ps
// A transform-point request is registered in the request stage and its result in the
// output register; the request waits in its stage while the output is stalled.
// Throughput: one request per cycle while no result is stalled; each stage holds
// one request, and every matrix update finishes in the cycle after acceptance, ahead
// of the next request. Reset: both stages empty, current matrix set to identity.
// ----------------------------------------------------------------------------
// Affine 2D transform composer core
// Keeps a 2x3 affine matrix, premultiplies elementary transforms onto it and
// applies it to points, in Q8.16 fixed point with saturation.
// ----------------------------------------------------------------------------
module affine_2d_transform_composer_core
    import aff2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              operation,
    input  logic signed [VAL_W-1:0] first_value,
    input  logic signed [VAL_W-1:0] second_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] out_x,
    output logic signed [VAL_W-1:0] out_y
);

    logic                    s_valid_reg;
    logic                    s_valid_next;
    op_t                     s_op_reg;
    logic signed [VAL_W-1:0] s_a_reg;
    logic signed [VAL_W-1:0] s_b_reg;
    logic signed [VAL_W-1:0] matrix_reg  [N_ENTRIES];
    logic signed [VAL_W-1:0] matrix_next [N_ENTRIES];
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [VAL_W-1:0] out_x_reg;
    logic signed [VAL_W-1:0] out_y_reg;

    logic                    s_is_point;
    logic                    out_free;
    logic                    s_fire;
    logic                    in_fire;
    logic signed [OPD_W-1:0] elem      [N_ENTRIES];
    logic signed [OPD_W-1:0] lane_p    [N_ENTRIES];
    logic signed [VAL_W-1:0] lane_u    [N_ENTRIES];
    logic signed [OPD_W-1:0] lane_q    [N_ENTRIES];
    logic signed [VAL_W-1:0] lane_v    [N_ENTRIES];
    logic signed [OPD_W-1:0] lane_r    [N_ENTRIES];
    logic signed [VAL_W-1:0] lane_sum  [N_ENTRIES];

    assign s_is_point = (s_op_reg == OP_POINT);
    assign out_free   = !out_valid_reg || out_ready;
    assign s_fire     = s_valid_reg && (!s_is_point || out_free);
    assign in_ready   = !s_valid_reg || s_fire;
    assign in_fire    = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;

    always_comb
    begin
        elem[0] = OPD_W'(ONE_VAL);
        elem[1] = '0;
        elem[2] = '0;
        elem[3] = '0;
        elem[4] = OPD_W'(ONE_VAL);
        elem[5] = '0;
        case (s_op_reg)
            OP_TRANSLATE:
            begin
                elem[2] = OPD_W'(s_a_reg);
                elem[5] = OPD_W'(s_b_reg);
            end
            OP_SCALE:
            begin
                elem[0] = OPD_W'(s_a_reg);
                elem[4] = OPD_W'(s_b_reg);
            end
            OP_ROTATE:
            begin
                elem[0] = OPD_W'(s_a_reg);
                elem[1] = -OPD_W'(s_b_reg);
                elem[3] = OPD_W'(s_b_reg);
                elem[4] = OPD_W'(s_a_reg);
            end
            OP_SHEAR:
            begin
                elem[1] = OPD_W'(s_a_reg);
                elem[3] = OPD_W'(s_b_reg);
            end
            default:
            begin
                elem[0] = OPD_W'(ONE_VAL);
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lane_p[3*i+j] = elem[3*i];
                lane_u[3*i+j] = matrix_reg[j];
                lane_q[3*i+j] = elem[3*i+1];
                lane_v[3*i+j] = matrix_reg[3+j];
                lane_r[3*i+j] = (j == 2) ? elem[3*i+2] : '0;
            end
        end
        // A point request borrows the first lane of each row.
        if (s_is_point)
        begin
            for (int i = 0; i < 2; i++)
            begin
                lane_p[3*i] = OPD_W'(matrix_reg[3*i]);
                lane_u[3*i] = s_a_reg;
                lane_q[3*i] = OPD_W'(matrix_reg[3*i+1]);
                lane_v[3*i] = s_b_reg;
                lane_r[3*i] = OPD_W'(matrix_reg[3*i+2]);
            end
        end
        for (int k = 0; k < N_ENTRIES; k++)
        begin
            lane_sum[k] = mac3(lane_p[k], lane_u[k], lane_q[k], lane_v[k], lane_r[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < N_ENTRIES; k++)
        begin
            matrix_next[k] = matrix_reg[k];
        end
        if (s_fire)
        begin
            case (s_op_reg)
                OP_IDENTITY:
                begin
                    matrix_next[0] = ONE_VAL;
                    matrix_next[1] = '0;
                    matrix_next[2] = '0;
                    matrix_next[3] = '0;
                    matrix_next[4] = ONE_VAL;
                    matrix_next[5] = '0;
                end
                OP_TRANSLATE, OP_SCALE, OP_ROTATE, OP_SHEAR:
                begin
                    for (int k = 0; k < N_ENTRIES; k++)
                    begin
                        matrix_next[k] = lane_sum[k];
                    end
                end
                default:
                begin
                    matrix_next[0] = matrix_reg[0];
                end
            endcase
        end
    end

    assign s_valid_next   = in_fire || (s_valid_reg && !s_fire);
    assign out_valid_next = (s_fire && s_is_point) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            matrix_reg[0] <= ONE_VAL;
            matrix_reg[1] <= '0;
            matrix_reg[2] <= '0;
            matrix_reg[3] <= '0;
            matrix_reg[4] <= ONE_VAL;
            matrix_reg[5] <= '0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < N_ENTRIES; k++)
            begin
                matrix_reg[k] <= matrix_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s_op_reg <= op_t'(operation);
            s_a_reg  <= first_value;
            s_b_reg  <= second_value;
        end
        if (s_fire && s_is_point)
        begin
            out_x_reg <= lane_sum[0];
            out_y_reg <= lane_sum[3];
        end
    end

`ifndef SYNTHESIS
    a_result_from_point: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s_valid_reg && s_op_reg == OP_POINT))
        else $error("result appeared without a transform-point request");

    a_identity_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_op_reg == OP_IDENTITY) |=>
            (matrix_reg[0] == ONE_VAL && matrix_reg[1] == '0 && matrix_reg[2] == '0 &&
             matrix_reg[3] == '0 && matrix_reg[4] == ONE_VAL && matrix_reg[5] == '0))
        else $error("identity request did not restore the identity matrix");

    a_matrix_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_fire || s_is_point) |=>
            ($stable(matrix_reg[0]) && $stable(matrix_reg[1]) && $stable(matrix_reg[2]) &&
             $stable(matrix_reg[3]) && $stable(matrix_reg[4]) && $stable(matrix_reg[5])))
        else $error("matrix changed without a matrix request");

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && !s_fire) |=> (s_valid_reg && $stable(s_op_reg) && $stable(s_a_reg)))
        else $error("stalled request was lost or overwritten");
`endif

endmodule

// ===== tb/affine_2d_transform_composer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine 2D transform composer core testbench
// Drives operation requests through a queue-fed driver with random idle
// bursts, predicts the current matrix and every transformed point in
// 64-bit arithmetic, and checks each result from a monitor with random
// output stalls and one long hold-off; the driver pauses to drain all results.
// ----------------------------------------------------------------------------
module affine_2d_transform_composer_core_tb;
    import aff2d_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam longint UNIT = (FRAC_BITS >= VAL_W - 1) ? longint'(VAL_MAX)
                                                       : (longint'(1) << FRAC_BITS);
    localparam longint SAT_HI = longint'(VAL_MAX);
    localparam longint SAT_LO = longint'(VAL_MIN);
    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_TAIL = 150;

    typedef struct {
        logic [2:0]              op;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        bit                      drain;
    } xf_req_t;

    typedef struct {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
    } point_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [2:0]              operation = OP_IDENTITY;
    logic signed [VAL_W-1:0] first_value = '0;
    logic signed [VAL_W-1:0] second_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;

    xf_req_t req_q[$];
    point_t  points_due[$];
    longint  xform[N_ENTRIES];
    point_t  got_want;
    int      total_items = 0;
    int      acc_cnt = 0;
    int      fail_cnt = 0;
    int      gap_cnt = 0;
    int      stall_cnt = 0;
    int      hold_cnt = 0;
    bit      hold_done = 1'b0;

    wire quiet = (acc_cnt + QUIET_TAIL >= total_items);
    wire calm  = ((acc_cnt / 120) % 3) == 1;

    affine_2d_transform_composer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp24(input longint v);
        if (v > SAT_HI)
        begin
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            return SAT_LO;
        end
        return v;
    endfunction

    // (p*u + q*v + r * 2^FRAC_BITS) >> FRAC_BITS with floor rounding, clamped.
    function automatic longint fx_dot(input longint p, input longint u, input longint q,
                                      input longint v, input longint r);
        longint s;
        s = p * u + q * v + (r <<< FRAC_BITS);
        return clamp24(s >>> FRAC_BITS);
    endfunction

    task automatic load_unit_matrix();
        xform[0] = UNIT;
        xform[1] = 0;
        xform[2] = 0;
        xform[3] = 0;
        xform[4] = UNIT;
        xform[5] = 0;
    endtask

    task automatic apply_request(input logic [2:0] op, input longint a, input longint b);
        longint e[6];
        longint nm[6];
        point_t pt;
        bit     compose;
        compose = 1'b1;
        case (op)
            OP_TRANSLATE: e = '{UNIT, 0, a, 0, UNIT, b};
            OP_SCALE:     e = '{a, 0, 0, 0, b, 0};
            OP_ROTATE:    e = '{a, -b, 0, b, a, 0};
            OP_SHEAR:     e = '{UNIT, a, 0, b, UNIT, 0};
            OP_IDENTITY:
            begin
                load_unit_matrix();
                compose = 1'b0;
            end
            OP_POINT:
            begin
                pt.x = VAL_W'(fx_dot(xform[0], a, xform[1], b, xform[2]));
                pt.y = VAL_W'(fx_dot(xform[3], a, xform[4], b, xform[5]));
                points_due.push_back(pt);
                compose = 1'b0;
            end
            default: compose = 1'b0;
        endcase
        if (compose)
        begin
            for (int i = 0; i < 2; i++)
            begin
                nm[3*i]   = fx_dot(e[3*i], xform[0], e[3*i+1], xform[3], 0);
                nm[3*i+1] = fx_dot(e[3*i], xform[1], e[3*i+1], xform[4], 0);
                nm[3*i+2] = fx_dot(e[3*i], xform[2], e[3*i+1], xform[5], e[3*i+2]);
            end
            xform = nm;
        end
    endtask

    function automatic int span(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic push_req(input logic [2:0] op, input int a, input int b, input bit drain);
        xf_req_t r;
        r.op = op;
        r.a = VAL_W'(a);
        r.b = VAL_W'(b);
        r.drain = drain;
        req_q.push_back(r);
    endtask

    // Driver: offers queued requests, holds each until accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_cnt > 0)
            begin
                gap_cnt = gap_cnt - 1;
                in_valid <= 1'b0;
            end
            else if (req_q.size() != 0 &&
                     !(req_q[0].drain && (in_valid || points_due.size() != 0)))
            begin
                operation <= req_q[0].op;
                first_value <= req_q[0].a;
                second_value <= req_q[0].b;
                in_valid <= 1'b1;
                void'(req_q.pop_front());
                if (!quiet && !calm && $urandom_range(0, 4) == 0)
                begin
                    gap_cnt = $urandom_range(1, 12);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks results, then updates the predicted matrix with the
    // request accepted at this edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            load_unit_matrix();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    $error("unexpected result: out_x %0d, out_y %0d", out_x, out_y);
                    fail_cnt = fail_cnt + 1;
                end
                else
                begin
                    got_want = points_due.pop_front();
                    if (out_x !== got_want.x)
                    begin
                        $error("out_x mismatch: expected %0d, actual %0d", got_want.x, out_x);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (out_y !== got_want.y)
                    begin
                        $error("out_y mismatch: expected %0d, actual %0d", got_want.y, out_y);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                apply_request(operation, longint'(first_value), longint'(second_value));
                acc_cnt <= acc_cnt + 1;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && acc_cnt >= 500)
            begin
                hold_done = 1'b1;
                hold_cnt = 300;
                out_ready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt = stall_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && !calm && $urandom_range(0, 6) == 0)
            begin
                stall_cnt = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int kind;
        int n;
        int base;
        logic [2:0] pick;

        // Directed requests: identity points, extremes, saturation, full
        // precision negation of the sine, and the unused codes.
        push_req(OP_POINT, int'(UNIT), 2 * int'(UNIT), 1'b0);
        push_req(OP_POINT, int'(SAT_HI), int'(SAT_LO), 1'b0);
        push_req(OP_IDENTITY, 12345, -999, 1'b0);
        push_req(OP_TRANSLATE, int'(SAT_HI), int'(SAT_LO), 1'b0);
        push_req(OP_POINT, 0, 0, 1'b0);
        push_req(OP_POINT, int'(SAT_HI), int'(SAT_HI), 1'b0);
        push_req(OP_SPARE_LO, -1, -1, 1'b0);
        push_req(OP_SPARE_HI, int'(SAT_LO), int'(SAT_HI), 1'b0);
        push_req(OP_POINT, int'(SAT_LO), int'(SAT_LO), 1'b0);
        push_req(OP_IDENTITY, -1, -1, 1'b0);
        push_req(OP_SCALE, int'(SAT_HI), int'(SAT_LO), 1'b0);
        push_req(OP_POINT, int'(SAT_LO), int'(SAT_HI), 1'b0);
        push_req(OP_IDENTITY, 0, 0, 1'b0);
        push_req(OP_ROTATE, 0, int'(SAT_LO), 1'b0);
        push_req(OP_POINT, int'(UNIT), int'(UNIT), 1'b0);
        push_req(OP_IDENTITY, 0, 0, 1'b0);
        push_req(OP_SHEAR, int'(SAT_HI), int'(SAT_LO), 1'b0);
        push_req(OP_POINT, int'(UNIT), -int'(UNIT), 1'b0);
        push_req(OP_IDENTITY, 0, 0, 1'b0);
        push_req(OP_ROTATE, 46341, 46341, 1'b0);
        push_req(OP_SCALE, -int'(UNIT), int'(UNIT) / 2, 1'b0);
        push_req(OP_TRANSLATE, int'(UNIT), -int'(UNIT), 1'b0);
        push_req(OP_POINT, 3 * int'(UNIT), -int'(UNIT), 1'b0);
        push_req(OP_POINT, -7, 5, 1'b1);

        base = req_q.size();
        while (req_q.size() < base + RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    push_req(OP_IDENTITY, $urandom, $urandom, 1'b0);
                end
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    pick = 3'($urandom_range(1, 4));
                    case (pick)
                        OP_TRANSLATE: push_req(pick, span(1 << 20), span(1 << 20), 1'b0);
                        OP_SCALE:     push_req(pick, span(131072), span(131072), 1'b0);
                        OP_ROTATE:    push_req(pick, span(65536), span(65536), 1'b0);
                        default:      push_req(pick, span(32768), span(32768), 1'b0);
                    endcase
                end
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    push_req(OP_POINT, span(1 << 21), span(1 << 21), 1'b0);
                end
            end
            else if (kind == 7)
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    push_req(3'($urandom_range(0, 7)), $urandom, $urandom, 1'b0);
                end
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    push_req(3'($urandom_range(1, 4)), $urandom, $urandom, 1'b0);
                end
                push_req(OP_POINT, $urandom, $urandom, 1'b0);
                push_req(OP_POINT, span(1 << 16), span(1 << 16), 1'b0);
            end
            else
            begin
                push_req(OP_POINT, span(1 << 22), span(1 << 22), 1'b1);
                push_req(OP_POINT, $urandom, $urandom, 1'b0);
            end
        end
        total_items = req_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || in_valid || points_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (points_due.size() != 0)
        begin
            $error("%0d expected results never arrived", points_due.size());
            fail_cnt = fail_cnt + 1;
        end
        if (fail_cnt == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule
